FILE: src/ugns_pkg.sv
package ugns_pkg;

  localparam int PosW = 24;
  localparam int SizeW = 23;
  localparam int DimW = 6;
  localparam int IdxW = 6;
  localparam int LinkW = 7;
  localparam int CountW = 7;
  localparam int AddrMaxW = 16;

  // empty marker in head and link entries
  localparam logic [LinkW-1:0] NoPart = 7'h40;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_SIZE = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_LINK,
    ST_Q_CELL,
    ST_Q_WAIT,
    ST_Q_LOOK,
    ST_Q_FIN
  } state_t;

  typedef struct packed {
    logic                head_we;
    logic                tail_we;
    logic [AddrMaxW-1:0] cell_wa;
    logic [LinkW-1:0]    head_wd;
    logic [IdxW-1:0]     tail_wd;
    logic [AddrMaxW-1:0] cell_ra;
    logic                next_we;
    logic [IdxW-1:0]     next_wa;
    logic [LinkW-1:0]    next_wd;
    logic [IdxW-1:0]     next_ra;
  } mem_req_t;

endpackage

FILE: src/ugns_div.sv
module ugns_div
  import ugns_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PosW-1:0]  dividend,
  input  logic [SizeW-1:0] divisor,
  output logic             done,
  output logic [PosW-1:0]  quotient
);

  localparam int CntW = $clog2(PosW + 1);

  logic [PosW-1:0]  rem;
  logic [PosW-1:0]  quo;
  logic [SizeW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [PosW-1:0]  trial;
  logic             fits;

  // restoring division, one quotient bit a cycle
  assign trial    = {rem[PosW-2:0], quo[PosW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, dvs}) : trial;
        quo <= {quo[PosW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(PosW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/ugns_store.sv
module ugns_store
  import ugns_pkg::*;
#(
  parameter int NumCells = 1024,
  parameter int NumParts = 64
) (
  input  logic             clk,
  input  mem_req_t         req,
  output logic [LinkW-1:0] head_q,
  output logic [IdxW-1:0]  tail_q,
  output logic [LinkW-1:0] next_q
);

  localparam int CW = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int PW = (NumParts > 1) ? $clog2(NumParts) : 1;

  logic [LinkW-1:0] head_mem [NumCells];
  logic [IdxW-1:0]  tail_mem [NumCells];
  logic [LinkW-1:0] next_mem [NumParts];

  always_ff @(posedge clk) begin
    if (req.head_we) begin
      head_mem[req.cell_wa[CW-1:0]] <= req.head_wd;
    end
    head_q <= head_mem[req.cell_ra[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.tail_we) begin
      tail_mem[req.cell_wa[CW-1:0]] <= req.tail_wd;
    end
    tail_q <= tail_mem[req.cell_ra[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_wa[PW-1:0]] <= req.next_wd;
    end
    next_q <= next_mem[req.next_ra[PW-1:0]];
  end

endmodule

FILE: src/uniform_grid_neighbor_search_core.sv
// channel   dir  signals                        content
// s         in   s_tvalid s_tready s_tdata      tdata: pos_x, pos_y; tuser: req_type
//                s_tuser
// m         out  m_tvalid m_tready m_tdata      tdata: particle_index, overflowed;
//                m_tuser m_tlast                tuser: has_index; tlast: last
// cfg       in   cfg_we cfg_addr cfg_data       0 grid_cols, 1 grid_rows, 2 cell_size
//
// reset and every clear item start a sweep of all MAX_COLS*MAX_ROWS cell heads,
// one per cycle, with s_tready low. a query or an insert below capacity runs two
// divisions on the shared divider; an insert then passes INS_RD, INS_WR, INS_LINK
// (INS_RD alone off grid), a query Q_CELL per neighbor cell, Q_WAIT and Q_LOOK per
// list read, Q_FIN to close, bound by registered memory reads. one item at a time;
// a stall on m holds the walk, the last result may wait while the next item is taken
module uniform_grid_neighbor_search_core
  import ugns_pkg::*;
#(
  parameter int MAX_COLS      = 32,
  parameter int MAX_ROWS      = 32,
  parameter int MAX_PARTICLES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [47:0]      s_tdata,   // pos_x [23:0], pos_y [47:24]
  input  logic [1:0]       s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // particle_index [5:0], overflowed [6], zero [7]
  output logic             m_tuser,   // has_index
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [SizeW-1:0] cfg_data
);

  localparam int NumCells = MAX_COLS * MAX_ROWS;
  localparam int CW       = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int PW       = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CellW    = PosW + 1;     // signed cell coordinate
  localparam int NbW      = CellW + 1;    // neighbor coordinate

  // config registers
  logic [DimW-1:0]  grid_cols;
  logic [DimW-1:0]  grid_rows;
  logic [SizeW-1:0] cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= DimW'(32);
      grid_rows <= DimW'(32);
      cell_size <= SizeW'(4096);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_COLS: grid_cols <= cfg_data[DimW-1:0];
        REG_ROWS: grid_rows <= cfg_data[DimW-1:0];
        REG_SIZE: cell_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the built grid
  logic [8:0] used_cols;
  logic [8:0] used_rows;
  assign used_cols = ({3'd0, grid_cols} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {3'd0, grid_cols};
  assign used_rows = ({3'd0, grid_rows} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {3'd0, grid_rows};

  state_t state, state_next;

  logic [CW-1:0]     sweep_cnt;
  logic [CountW-1:0] particle_count;
  logic              overflow_flag;
  logic              is_query;
  logic [PosW-1:0]   pos_y_hold;
  logic              neg_y;
  logic              neg_x;
  logic [CellW-1:0]  cx;
  logic [CellW-1:0]  cy;
  logic [1:0]        nb_x;
  logic [1:0]        nb_y;
  logic [IdxW-1:0]   new_p;
  logic [CW-1:0]     ins_cell;
  logic              from_head;
  logic [LinkW-1:0]  cur_p;
  logic              pend_valid;
  logic [IdxW-1:0]   pend_p;

  // shared divider
  logic             div_start;
  logic [PosW-1:0]  div_dividend;
  logic             div_done;
  logic [PosW-1:0]  div_quo;
  logic [SizeW-1:0] div_divisor;

  assign div_divisor = (cell_size == '0) ? SizeW'(1) : cell_size;

  ugns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // memories
  mem_req_t         mreq;
  logic [LinkW-1:0] head_q;
  logic [IdxW-1:0]  tail_q;
  logic [LinkW-1:0] next_q;

  ugns_store #(
    .NumCells (NumCells),
    .NumParts (MAX_PARTICLES)
  ) u_store (
    .clk    (clk),
    .req    (mreq),
    .head_q (head_q),
    .tail_q (tail_q),
    .next_q (next_q)
  );

  // accepted item
  logic s_acc;
  logic [PosW-1:0] in_x;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_x     = s_tdata[PosW-1:0];

  // neighbor cell of the current walk position
  logic [NbW-1:0] nx;
  logic [NbW-1:0] ny;
  logic           nb_in;
  logic [CW-1:0]  nb_cell;
  logic [16:0]    nb_prod;

  assign nx = {cx[CellW-1], cx} + NbW'(nb_x) - NbW'(1);
  assign ny = {cy[CellW-1], cy} + NbW'(nb_y) - NbW'(1);
  assign nb_in = !nx[NbW-1] && !ny[NbW-1] &&
                 (nx < NbW'(used_cols)) && (ny < NbW'(used_rows));
  assign nb_prod = 17'(ny[7:0]) * 17'(used_cols) + 17'(nx[8:0]);
  assign nb_cell = CW'(nb_prod);

  // signed quotient, truncated toward zero
  logic [CellW-1:0] quo_signed;
  logic             quo_neg;
  assign quo_neg    = (state == ST_DIVX) ? neg_x : neg_y;
  assign quo_signed = quo_neg ? (CellW'(0) - {1'b0, div_quo}) : {1'b0, div_quo};

  // output slot
  logic out_free;
  logic push_ok;
  logic nb_last;
  logic out_load;
  assign out_free = !m_tvalid || m_tready;
  assign push_ok  = !pend_valid || out_free;
  assign nb_last  = (nb_x == 2'd2) && (nb_y == 2'd2);
  assign out_load = ((state == ST_Q_LOOK) && !cur_p[IdxW] && push_ok && pend_valid) ||
                    ((state == ST_Q_FIN) && out_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: if (sweep_cnt == CW'(NumCells - 1)) begin
        state_next = ST_IDLE;
      end
      ST_IDLE: if (s_acc) begin
        priority case (req_t'(s_tuser))
          REQ_CLEAR:  state_next = ST_SWEEP;
          REQ_INSERT: state_next = (particle_count >= CountW'(MAX_PARTICLES)) ? ST_IDLE
                                                                               : ST_DIVX;
          REQ_QUERY:  state_next = ST_DIVX;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_DIVX: if (div_done) begin
        state_next = ST_DIVY;
      end
      ST_DIVY: if (div_done) begin
        state_next = is_query ? ST_Q_CELL : ST_INS_RD;
      end
      ST_INS_RD: state_next = nb_in ? ST_INS_WR : ST_IDLE;
      ST_INS_WR: state_next = ST_INS_LINK;
      ST_INS_LINK: state_next = ST_IDLE;
      ST_Q_CELL: begin
        if (nb_in) begin
          state_next = ST_Q_WAIT;
        end else if (nb_last) begin
          state_next = ST_Q_FIN;
        end
      end
      ST_Q_WAIT: state_next = ST_Q_LOOK;
      ST_Q_LOOK: begin
        if (cur_p[IdxW]) begin
          state_next = nb_last ? ST_Q_FIN : ST_Q_CELL;
        end else if (push_ok) begin
          state_next = ST_Q_WAIT;
        end
      end
      ST_Q_FIN: if (out_free) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    mreq         = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    mreq.cell_ra = AddrMaxW'(nb_cell);
    mreq.next_ra = cur_p[IdxW-1:0];
    unique case (state)
      ST_SWEEP: begin
        mreq.head_we = 1'b1;
        mreq.cell_wa = AddrMaxW'(sweep_cnt);
        mreq.head_wd = NoPart;
      end
      ST_IDLE: begin
        div_start    = s_acc && ((req_t'(s_tuser) == REQ_QUERY) ||
                       ((req_t'(s_tuser) == REQ_INSERT) &&
                        (particle_count < CountW'(MAX_PARTICLES))));
        div_dividend = in_x[PosW-1] ? (PosW'(0) - in_x) : in_x;
      end
      ST_DIVX: begin
        div_start    = div_done;
        div_dividend = neg_y ? (PosW'(0) - pos_y_hold) : pos_y_hold;
      end
      ST_INS_WR: begin
        // empty cell takes a new head, otherwise link behind the tail
        mreq.head_we = head_q[IdxW];
        mreq.tail_we = 1'b1;
        mreq.cell_wa = AddrMaxW'(ins_cell);
        mreq.head_wd = LinkW'(new_p);
        mreq.tail_wd = new_p;
        mreq.next_we = !head_q[IdxW];
        mreq.next_wa = IdxW'(tail_q[PW-1:0]);
        mreq.next_wd = LinkW'(new_p);
      end
      ST_INS_LINK: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = new_p;
        mreq.next_wd = NoPart;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_SWEEP;
      sweep_cnt      <= '0;
      particle_count <= '0;
      overflow_flag  <= 1'b0;
      pend_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: sweep_cnt <= sweep_cnt + 1'b1;
        ST_IDLE: if (s_acc) begin
          is_query   <= (req_t'(s_tuser) == REQ_QUERY);
          pos_y_hold <= s_tdata[2*PosW-1:PosW];
          neg_y      <= s_tdata[2*PosW-1];
          neg_x      <= in_x[PosW-1];
          // a query walks from the lower left neighbor, an insert uses the center
          nb_x       <= (req_t'(s_tuser) == REQ_QUERY) ? 2'd0 : 2'd1;
          nb_y       <= (req_t'(s_tuser) == REQ_QUERY) ? 2'd0 : 2'd1;
          priority case (req_t'(s_tuser))
            REQ_CLEAR: begin
              sweep_cnt      <= '0;
              particle_count <= '0;
              overflow_flag  <= 1'b0;
            end
            REQ_INSERT: begin
              if (particle_count >= CountW'(MAX_PARTICLES)) begin
                overflow_flag <= 1'b1;
              end else begin
                new_p          <= IdxW'(particle_count);
                particle_count <= particle_count + 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_DIVX: if (div_done) begin
          cx <= quo_signed;
        end
        ST_DIVY: if (div_done) begin
          cy <= quo_signed;
        end
        ST_INS_RD: ins_cell <= nb_cell;
        ST_Q_CELL: begin
          from_head <= 1'b1;
          if (!nb_in && !nb_last) begin
            nb_x <= (nb_x == 2'd2) ? 2'd0 : nb_x + 1'b1;
            nb_y <= (nb_x == 2'd2) ? nb_y + 1'b1 : nb_y;
          end
        end
        ST_Q_WAIT: cur_p <= from_head ? head_q : next_q;
        ST_Q_LOOK: begin
          if (cur_p[IdxW]) begin
            if (!nb_last) begin
              nb_x <= (nb_x == 2'd2) ? 2'd0 : nb_x + 1'b1;
              nb_y <= (nb_x == 2'd2) ? nb_y + 1'b1 : nb_y;
            end
          end else if (push_ok) begin
            // older pending hit moves out, this one waits to learn if it is last
            if (pend_valid) begin
              m_tdata  <= {1'b0, overflow_flag, pend_p};
              m_tuser  <= 1'b1;
              m_tlast  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_p     <= cur_p[IdxW-1:0];
            from_head  <= 1'b0;
          end
        end
        ST_Q_FIN: if (out_free) begin
          m_tdata    <= {1'b0, overflow_flag, pend_valid ? pend_p : IdxW'(0)};
          m_tuser    <= pend_valid;
          m_tlast    <= 1'b1;
          pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: verif/tb.sv
module tb;
  import ugns_pkg::*;

  localparam int LimitCycles = 1000000;
  localparam int SettleCycles = 1200;   // sweep of all cell heads plus a pending insert
  localparam int NumCells = 1024;
  localparam int NumParts = 64;

  typedef struct {
    logic [5:0] idx;
    logic       has;
    logic       last;
    logic       ovf;
  } hit_t;

  // grid model and expected neighbor lists
  class neighbor_board;
    logic [6:0]  head[NumCells];
    logic [5:0]  tail[NumCells];
    logic [6:0]  link[NumParts];
    int unsigned count;
    logic        ovf;
    logic [5:0]  cols, rows;
    logic [22:0] size;
    hit_t        hits_due[$];
    int          errors;

    function new();
      cols = 32;
      rows = 32;
      size = 4096;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (head[i]) head[i] = NoPart;
      count = 0;
      ovf = 0;
    endfunction

    function void set_reg(reg_idx_t a, logic [22:0] v);
      case (a)
        REG_COLS: cols = v[5:0];
        REG_ROWS: rows = v[5:0];
        REG_SIZE: size = v;
        default: ;
      endcase
    endfunction

    function int ucols();
      return cols > 32 ? 32 : int'(cols);
    endfunction

    function int urows();
      return rows > 32 ? 32 : int'(rows);
    endfunction

    function bit on_grid(int cx, int cy);
      return cx >= 0 && cy >= 0 && cx < ucols() && cy < urows();
    endfunction

    // called for each accepted input item
    function void note_item(logic [1:0] r, logic [23:0] x, logic [23:0] y);
      int   cs, cx, cy, c, nx, ny, g;
      int   p;
      hit_t h;
      hit_t found[$];
      cs = (size == 0) ? 1 : int'(size);
      cx = int'($signed(x)) / cs;
      cy = int'($signed(y)) / cs;
      case (r)
        REQ_CLEAR: wipe();
        REQ_INSERT: begin
          if (count >= NumParts) begin
            ovf = 1;
          end else begin
            p = count;
            count++;
            if (on_grid(cx, cy)) begin
              c = (cy * ucols() + cx) % NumCells;
              if (head[c][6]) head[c] = p[6:0];
              else link[tail[c]] = p[6:0];
              tail[c] = p[5:0];
              link[p] = NoPart;
            end
          end
        end
        REQ_QUERY: begin
          // rows y-1..y+1, columns x-1..x+1, each cell in insertion order
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              nx = cx + dx;
              ny = cy + dy;
              if (on_grid(nx, ny)) begin
                c = (ny * ucols() + nx) % NumCells;
                p = head[c];
                for (g = 0; g < NumParts && !p[6] && found.size() < NumParts; g++) begin
                  h.idx = p[5:0];
                  h.has = 1;
                  h.last = 0;
                  h.ovf = ovf;
                  found.insert(found.size(), h);
                  p = link[p[5:0]];
                end
              end
            end
          end
          if (found.size() == 0) begin
            h.idx = 0;
            h.has = 0;
            h.last = 1;
            h.ovf = ovf;
            found.insert(found.size(), h);
          end else begin
            found[found.size()-1].last = 1;
          end
          foreach (found[i]) hits_due.insert(hits_due.size(), found[i]);
        end
        default: ;   // unused code is ignored
      endcase
    endfunction

    function void check_result(logic [7:0] d, logic u, logic l);
      hit_t e;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result idx=%0d has=%0b last=%0b ovf=%0b",
                 $time, d[5:0], u, l, d[6]);
        errors++;
        return;
      end
      e = hits_due.pop_front();
      if (d[5:0] !== e.idx || u !== e.has || l !== e.last || d[6] !== e.ovf) begin
        $display({"%0t: mismatch expected idx=%0d has=%0b last=%0b ovf=%0b,",
                  " got idx=%0d has=%0b last=%0b ovf=%0b"},
                 $time, e.idx, e.has, e.last, e.ovf, d[5:0], u, l, d[6]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = REQ_NONE;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = REG_COLS;
  logic [22:0] cfg_data = '0;

  neighbor_board board = new();
  bit          calm_in = 0;    // no gaps on the input side
  bit          calm_out = 0;   // no stalls on the output side
  int          stall_left = 0;
  int unsigned cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  uniform_grid_neighbor_search_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // result side: check on handshake, then draw the stall before the next item
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        board.check_result(m_tdata, m_tuser, m_tlast);
        stall_left = calm_out ? 0 : $urandom_range(0, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LimitCycles) begin
      $display("uniform_grid_neighbor_search_core verification failed");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge the item is taken
  task automatic send_item(req_t r, logic [23:0] x, logic [23:0] y);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {y, x};
    s_tuser <= r;
    do @(posedge clk); while (!s_tready);
    board.note_item(r, x, y);
  endtask

  // only while the block is idle
  task automatic write_reg(reg_idx_t a, logic [22:0] v);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(a, v);
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (board.hits_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one coordinate, mostly near the grid in use, sometimes anywhere
  function automatic logic [23:0] pick_pos(int cells);
    longint cs, v;
    cs = (board.size == 0) ? 1 : longint'(board.size);
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    v = longint'($urandom_range(0, 32'hFFFF_FFFF)) % ((cells + 2) * cs) - cs;
    if (v > 64'sd8388607) v = 8388607;
    if (v < -64'sd8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic random_phase(int n, logic [5:0] c, logic [5:0] r, logic [22:0] s);
    int   k;
    req_t q;
    settle();
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_SIZE, s);
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      // mostly inserts and queries so the lists grow and capacity is reached
      q = (k < 2) ? REQ_CLEAR : (k < 57) ? REQ_INSERT : (k < 95) ? REQ_QUERY : REQ_NONE;
      send_item(q, pick_pos(board.ucols()), pick_pos(board.urows()));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part at reset settings: 16.0 cells, 32 by 32
    send_item(REQ_QUERY, 24'd0, 24'd0);                // empty query
    send_item(REQ_INSERT, 24'd0, 24'd0);
    send_item(REQ_INSERT, 24'hFFFFFF, 24'hFFFFFF);     // just below zero lands in cell 0
    send_item(REQ_INSERT, 24'd4095, 24'd4095);
    send_item(REQ_INSERT, 24'd4096, 24'd0);
    send_item(REQ_INSERT, 24'd131071, 24'd131071);     // last cell
    send_item(REQ_INSERT, 24'd131072, 24'd0);          // off grid, still numbered
    send_item(REQ_INSERT, 24'h7FFFFF, 24'h800000);     // field extremes, off grid
    send_item(REQ_INSERT, 24'h800000, 24'h7FFFFF);
    send_item(REQ_NONE, 24'h7FFFFF, 24'h7FFFFF);       // unused code
    send_item(REQ_QUERY, 24'd0, 24'd0);
    send_item(REQ_QUERY, 24'd4096, 24'd4096);
    send_item(REQ_QUERY, 24'd131071, 24'd131071);
    send_item(REQ_QUERY, 24'h800000, 24'h800000);
    send_item(REQ_INSERT, 24'd8192, 24'd4096);
    send_item(REQ_QUERY, 24'd4096, 24'd4096);
    send_item(REQ_CLEAR, 24'd0, 24'd0);
    send_item(REQ_QUERY, 24'd0, 24'd0);
    send_item(REQ_INSERT, 24'd100, 24'd100);
    send_item(REQ_QUERY, 24'hFFFFFF, 24'hFFFFFF);

    // registers changed while particles are stored
    settle();
    write_reg(REG_NONE, 23'h7FFFFF);
    write_reg(REG_COLS, 6'd2);
    send_item(REQ_QUERY, 24'd0, 24'd0);

    // random phases across settings, extremes included
    random_phase(20, 6'd1, 6'd1, 23'd1);
    random_phase(20, 6'd63, 6'd63, 23'h7FFFFF);   // above maximum, largest cell
    random_phase(15, 6'd0, 6'd5, 23'd0);          // empty grid, zero cell size
    random_phase(20, 6'd7, 6'd3, 23'd300);
    random_phase(25, 6'd32, 6'd32, 23'd4096);

    settle();
    if (board.errors == 0 && board.hits_due.size() == 0) begin
      $display("uniform_grid_neighbor_search_core verification clean");
    end else begin
      $display("uniform_grid_neighbor_search_core verification failed");
    end
    $finish;
  end

endmodule
